>>> rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LCI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LCI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/lci_pkg.sv
// Package: request and result types and status codes of the line/circle intersection block.
`default_nettype none

package lci_pkg;

    typedef enum logic [1:0] {
        ST_TWO      = 2'd0,
        ST_TANGENT  = 2'd1,
        ST_NONE     = 2'd2,
        ST_VERTICAL = 2'd3
    } status_t;

    typedef struct packed {
        logic signed [31:0] line_ax;
        logic signed [31:0] line_ay;
        logic signed [31:0] line_bx;
        logic signed [31:0] line_by;
        logic signed [31:0] centre_x;
        logic signed [31:0] centre_y;
        logic        [30:0] radius;
    } in_t;

    typedef struct packed {
        logic signed [31:0] first_x;
        logic signed [31:0] first_y;
        logic signed [31:0] second_x;
        logic signed [31:0] second_y;
        status_t            status;
        logic               saturated;
    } out_t;

endpackage

`default_nettype wire

>>> rtl/line_circle_intersection.sv
// Top level: pipelined intersection of a line through two points with a circle.
//
// Usage
//   Request channel (req_valid, req_stall, req_data) carries two line points and
//   the circle centre in signed Q16.16 and the radius in unsigned Q15.16. A
//   request is taken on a rising edge with req_valid high and req_stall low.
//   Result channel (rsp_valid, rsp_stall, rsp_data) returns both crossing points,
//   a status code and a saturation flag, one result per request, in order.
// Throughput and depth
//   One request enters per cycle while req_stall is low. The depth is set by the
//   64-stage square root (two radicand bits per stage) and the 40-stage
//   restoring divider (one quotient bit per stage, four lanes side by side);
//   multiplies are two-stage partial products.
// Reset
//   rst_n clears all valid bits, including the output and skid flags; the
//   pipeline comes up empty and ready.
// Stall
//   The output register is backed by one skid register. When the receiver stalls
//   and the skid fills, req_stall rises and the whole pipeline holds in place.
`default_nettype none

module line_circle_intersection (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  lci_pkg::in_t  req_data,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output lci_pkg::out_t rsp_data
);
    import lci_pkg::*;

    localparam int SQ_N  = 64;
    localparam int DIV_N = 40;
    localparam int LANES = 4;

    localparam logic signed [41:0] LIM40  = 42'sd1099511627776;
    localparam logic signed [42:0] MAX32  = 43'sd2147483647;
    localparam logic signed [42:0] MIN32  = -43'sd2147483648;

    typedef struct packed {
        logic               vert;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
    } geo_t;

    typedef struct packed {
        geo_t               geo;
        logic               none;
        logic               tan;
        logic signed [66:0] c;
        logic        [65:0] l;
    } side_t;

    typedef struct packed {
        logic               vert;
        logic               none;
        logic               tan;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic        [65:0] l;
        logic [LANES-1:0]   neg;
        logic [LANES-1:0]   ovf;
    } fin_t;

    // Global advance: hold every pipeline stage while the skid register is occupied.
    logic en;
    logic sk_v_reg;
    assign en        = !sk_v_reg;
    assign req_stall = sk_v_reg;

    // ---------------------------------------------------------------- stage A
    logic               a_v_reg;
    geo_t               a_geo_reg;
    logic signed [32:0] a_px_reg;
    logic signed [32:0] a_py_reg;
    logic        [30:0] a_r_reg;
    geo_t               a_geo_next;

    always_comb
    begin
        a_geo_next.dx   = 33'(req_data.line_ax) - 33'(req_data.line_bx);
        a_geo_next.dy   = 33'(req_data.line_ay) - 33'(req_data.line_by);
        a_geo_next.cx   = req_data.centre_x;
        a_geo_next.cy   = req_data.centre_y;
        a_geo_next.vert = (req_data.line_ax == req_data.line_bx);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_geo_reg <= a_geo_next;
            a_px_reg  <= 33'(req_data.line_ax) - 33'(req_data.centre_x);
            a_py_reg  <= 33'(req_data.line_ay) - 33'(req_data.centre_y);
            a_r_reg   <= req_data.radius;
        end
    end

    // --------------------------------------------------------- multiply one
    logic signed [65:0] pydx, dypx, dxdx, dydy, rr;
    logic               m1_v_reg [2];
    geo_t               m1_geo_reg [2];

    lci_mul #(.AW(33), .BW(33)) u_m_pydx (.clk(clk), .en(en), .a(a_py_reg),
        .b(a_geo_reg.dx), .p(pydx));
    lci_mul #(.AW(33), .BW(33)) u_m_dypx (.clk(clk), .en(en), .a(a_geo_reg.dy),
        .b(a_px_reg), .p(dypx));
    lci_mul #(.AW(33), .BW(33)) u_m_dxdx (.clk(clk), .en(en), .a(a_geo_reg.dx),
        .b(a_geo_reg.dx), .p(dxdx));
    lci_mul #(.AW(33), .BW(33)) u_m_dydy (.clk(clk), .en(en), .a(a_geo_reg.dy),
        .b(a_geo_reg.dy), .p(dydy));
    lci_mul #(.AW(33), .BW(33)) u_m_rr (.clk(clk), .en(en), .a($signed({2'b00, a_r_reg})),
        .b($signed({2'b00, a_r_reg})), .p(rr));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_geo_reg[0] <= a_geo_reg;
            m1_geo_reg[1] <= m1_geo_reg[0];
        end
    end

    // ---------------------------------------------------------------- stage C
    logic               c_v_reg;
    geo_t               c_geo_reg;
    logic signed [66:0] c_c_reg;
    logic signed [66:0] c_l_reg;
    logic signed [65:0] c_rr_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_geo_reg <= m1_geo_reg[1];
            c_c_reg   <= 67'(pydx) - 67'(dypx);
            c_l_reg   <= 67'(dxdx) + 67'(dydy);
            c_rr_reg  <= rr;
        end
    end

    // --------------------------------------------------------- multiply two
    logic signed [133:0] cc;
    logic signed [132:0] rrl;
    logic                m2_v_reg [2];
    geo_t                m2_geo_reg [2];
    logic signed [66:0]  m2_c_reg [2];
    logic        [65:0]  m2_l_reg [2];

    lci_mul #(.AW(67), .BW(67)) u_m_cc (.clk(clk), .en(en), .a(c_c_reg), .b(c_c_reg),
        .p(cc));
    lci_mul #(.AW(66), .BW(67)) u_m_rrl (.clk(clk), .en(en), .a(c_rr_reg), .b(c_l_reg),
        .p(rrl));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m2_geo_reg[0] <= c_geo_reg;
            m2_geo_reg[1] <= m2_geo_reg[0];
            m2_c_reg[0]   <= c_c_reg;
            m2_c_reg[1]   <= m2_c_reg[0];
            m2_l_reg[0]   <= c_l_reg[65:0];
            m2_l_reg[1]   <= m2_l_reg[0];
        end
    end

    // ------------------------------------------------------- discriminant D
    logic                d_v_reg;
    side_t               d_side_reg;
    logic        [127:0] d_rad_reg;
    logic signed [134:0] disc;

    assign disc = 135'(rrl) - 135'(cc);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_side_reg.geo  <= m2_geo_reg[1];
            d_side_reg.none <= disc[134];
            d_side_reg.tan  <= (disc == '0);
            d_side_reg.c    <= m2_c_reg[1];
            d_side_reg.l    <= m2_l_reg[1];
            // Feed zero into the root when there is no crossing.
            d_rad_reg       <= disc[134] ? '0 : disc[127:0];
        end
    end

    // ---------------------------------------------------------- square root
    logic          sq_v_reg    [SQ_N];
    side_t         sq_side_reg [SQ_N];
    logic [65:0]   sq_rem_reg  [SQ_N];
    logic [63:0]   sq_root_reg [SQ_N];
    logic [127:0]  sq_rad_reg  [SQ_N];
    logic [65:0]   sq_rem_next [SQ_N];
    logic [63:0]   sq_root_next[SQ_N];
    logic [127:0]  sq_rad_next [SQ_N];

    always_comb
    begin
        logic [65:0]  rem_in;
        logic [63:0]  root_in;
        logic [127:0] rad_in;
        logic [67:0]  remx;
        logic [67:0]  trial;
        for (int k = 0; k < SQ_N; k++)
        begin
            if (k == 0)
            begin
                rem_in  = '0;
                root_in = '0;
                rad_in  = d_rad_reg;
            end
            else
            begin
                rem_in  = sq_rem_reg[k-1];
                root_in = sq_root_reg[k-1];
                rad_in  = sq_rad_reg[k-1];
            end
            remx  = {rem_in, rad_in[127:126]};
            trial = {2'b00, root_in, 2'b01};
            if (remx >= trial)
            begin
                sq_rem_next[k]  = 66'(remx - trial);
                sq_root_next[k] = {root_in[62:0], 1'b1};
            end
            else
            begin
                sq_rem_next[k]  = remx[65:0];
                sq_root_next[k] = {root_in[62:0], 1'b0};
            end
            sq_rad_next[k] = {rad_in[125:0], 2'b00};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < SQ_N; k++)
            begin
                sq_rem_reg[k]  <= sq_rem_next[k];
                sq_root_reg[k] <= sq_root_next[k];
                sq_rad_reg[k]  <= sq_rad_next[k];
                sq_side_reg[k] <= (k == 0) ? d_side_reg : sq_side_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    // ------------------------------------------------------- multiply three
    side_t               s_side;
    logic signed [64:0]  s_root;
    logic signed [33:0]  s_adx;
    logic signed [32:0]  s_sdy;
    logic signed [99:0]  dyc, dxc;
    logic signed [98:0]  adxs;
    logic signed [97:0]  sdys;
    logic                m3_v_reg [2];
    side_t               m3_side_reg [2];

    assign s_side = sq_side_reg[SQ_N-1];
    assign s_root = $signed({1'b0, sq_root_reg[SQ_N-1]});
    assign s_adx  = s_side.geo.dx[32] ? -34'(s_side.geo.dx) : 34'(s_side.geo.dx);
    assign s_sdy  = s_side.geo.dx[32] ? -s_side.geo.dy : s_side.geo.dy;

    lci_mul #(.AW(33), .BW(67)) u_m_dyc (.clk(clk), .en(en), .a(s_side.geo.dy),
        .b(s_side.c), .p(dyc));
    lci_mul #(.AW(34), .BW(65)) u_m_adxs (.clk(clk), .en(en), .a(s_adx), .b(s_root),
        .p(adxs));
    lci_mul #(.AW(33), .BW(67)) u_m_dxc (.clk(clk), .en(en), .a(s_side.geo.dx),
        .b(s_side.c), .p(dxc));
    lci_mul #(.AW(33), .BW(65)) u_m_sdys (.clk(clk), .en(en), .a(s_sdy), .b(s_root),
        .p(sdys));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m3_side_reg[0] <= s_side;
            m3_side_reg[1] <= m3_side_reg[0];
        end
    end

    // ------------------------------------------------------------ numerators
    logic               n_v_reg;
    side_t              n_side_reg;
    logic signed [100:0] n_reg [LANES];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_side_reg <= m3_side_reg[1];
            n_reg[0]   <= -101'(dyc) + 101'(adxs);
            n_reg[1]   <= -101'(dyc) - 101'(adxs);
            n_reg[2]   <= 101'(dxc) + 101'(sdys);
            n_reg[3]   <= 101'(dxc) - 101'(sdys);
        end
    end

    // ----------------------------------------------------- divider prepare
    logic         p_v_reg;
    fin_t         p_fin_reg;
    logic [65:0]  p_rem_reg [LANES];
    logic [39:0]  p_q_reg   [LANES];
    logic [100:0] n_mag     [LANES];
    fin_t         p_fin_next;

    always_comb
    begin
        p_fin_next.vert = n_side_reg.geo.vert;
        p_fin_next.none = n_side_reg.none;
        p_fin_next.tan  = n_side_reg.tan;
        p_fin_next.cx   = n_side_reg.geo.cx;
        p_fin_next.cy   = n_side_reg.geo.cy;
        p_fin_next.l    = n_side_reg.l;
        for (int j = 0; j < LANES; j++)
        begin
            n_mag[j]          = n_reg[j][100] ? 101'(-n_reg[j]) : n_reg[j];
            p_fin_next.neg[j] = n_reg[j][100];
            // Quotient of 2^40 or more saturates anyway: flag it and skip the bits.
            p_fin_next.ovf[j] = (106'(n_mag[j]) >= {n_side_reg.l, 40'd0});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_fin_reg <= p_fin_next;
            for (int j = 0; j < LANES; j++)
            begin
                p_rem_reg[j] <= {5'd0, n_mag[j][100:40]};
                p_q_reg[j]   <= n_mag[j][39:0];
            end
        end
    end

    // ------------------------------------------------------------- divider
    logic         dv_v_reg   [DIV_N];
    fin_t         dv_fin_reg [DIV_N];
    logic [65:0]  dv_rem_reg [DIV_N][LANES];
    logic [39:0]  dv_q_reg   [DIV_N][LANES];
    logic [65:0]  dv_rem_next[DIV_N][LANES];
    logic [39:0]  dv_q_next  [DIV_N][LANES];

    always_comb
    begin
        logic [65:0] rem_in;
        logic [39:0] q_in;
        logic [65:0] lval;
        logic [66:0] remx;
        for (int k = 0; k < DIV_N; k++)
        begin
            lval = (k == 0) ? p_fin_reg.l : dv_fin_reg[(k == 0) ? 0 : k-1].l;
            for (int j = 0; j < LANES; j++)
            begin
                if (k == 0)
                begin
                    rem_in = p_rem_reg[j];
                    q_in   = p_q_reg[j];
                end
                else
                begin
                    rem_in = dv_rem_reg[k-1][j];
                    q_in   = dv_q_reg[k-1][j];
                end
                remx = {rem_in, q_in[39]};
                if (remx >= {1'b0, lval})
                begin
                    dv_rem_next[k][j] = 66'(remx - {1'b0, lval});
                    dv_q_next[k][j]   = {q_in[38:0], 1'b1};
                end
                else
                begin
                    dv_rem_next[k][j] = remx[65:0];
                    dv_q_next[k][j]   = {q_in[38:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DIV_N; k++)
            begin
                dv_fin_reg[k] <= (k == 0) ? p_fin_reg : dv_fin_reg[(k == 0) ? 0 : k-1];
                for (int j = 0; j < LANES; j++)
                begin
                    dv_rem_reg[k][j] <= dv_rem_next[k][j];
                    dv_q_reg[k][j]   <= dv_q_next[k][j];
                end
            end
        end
    end

    // ---------------------------------------------------------- final stage
    logic        f_v_reg;
    out_t        f_out_reg;
    out_t        f_out_next;
    fin_t        f_fin;
    logic signed [31:0] f_coord [LANES];
    logic [LANES-1:0]   f_sat;

    assign f_fin = dv_fin_reg[DIV_N-1];

    always_comb
    begin
        logic        [41:0] mag42;
        logic signed [41:0] val;
        logic signed [42:0] sum;
        logic signed [31:0] cen;
        for (int j = 0; j < LANES; j++)
        begin
            cen   = (j < 2) ? f_fin.cx : f_fin.cy;
            // Round toward minus infinity: bump a negative quotient that left a remainder.
            mag42 = 42'(dv_q_reg[DIV_N-1][j])
                  + 42'(f_fin.neg[j] && (|dv_rem_reg[DIV_N-1][j]));
            if (f_fin.ovf[j])
                val = f_fin.neg[j] ? -LIM40 : LIM40;
            else
                val = f_fin.neg[j] ? -$signed(mag42) : $signed(mag42);
            sum = 43'(cen) + 43'(val);
            f_sat[j] = 1'b0;
            if (sum > MAX32)
            begin
                f_coord[j] = 32'(MAX32);
                f_sat[j]   = 1'b1;
            end
            else if (sum < MIN32)
            begin
                f_coord[j] = 32'(MIN32);
                f_sat[j]   = 1'b1;
            end
            else
                f_coord[j] = 32'(sum);
        end

        f_out_next = '0;
        if (f_fin.vert)
            f_out_next.status = ST_VERTICAL;
        else if (f_fin.none)
            f_out_next.status = ST_NONE;
        else
        begin
            // Lanes: plus root x, minus root x, plus root y, minus root y.
            f_out_next.first_x   = f_coord[0];
            f_out_next.second_x  = f_coord[1];
            f_out_next.first_y   = f_coord[2];
            f_out_next.second_y  = f_coord[3];
            f_out_next.status    = f_fin.tan ? ST_TANGENT : ST_TWO;
            f_out_next.saturated = |f_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            f_out_reg <= f_out_next;
    end

    // ------------------------------------------------------------ valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg  <= 1'b0;
            m1_v_reg <= '{default: 1'b0};
            c_v_reg  <= 1'b0;
            m2_v_reg <= '{default: 1'b0};
            d_v_reg  <= 1'b0;
            sq_v_reg <= '{default: 1'b0};
            m3_v_reg <= '{default: 1'b0};
            n_v_reg  <= 1'b0;
            p_v_reg  <= 1'b0;
            dv_v_reg <= '{default: 1'b0};
            f_v_reg  <= 1'b0;
        end
        else if (en)
        begin
            a_v_reg     <= req_valid;
            m1_v_reg[0] <= a_v_reg;
            m1_v_reg[1] <= m1_v_reg[0];
            c_v_reg     <= m1_v_reg[1];
            m2_v_reg[0] <= c_v_reg;
            m2_v_reg[1] <= m2_v_reg[0];
            d_v_reg     <= m2_v_reg[1];
            for (int k = 0; k < SQ_N; k++)
                sq_v_reg[k] <= (k == 0) ? d_v_reg : sq_v_reg[(k == 0) ? 0 : k-1];
            m3_v_reg[0] <= sq_v_reg[SQ_N-1];
            m3_v_reg[1] <= m3_v_reg[0];
            n_v_reg     <= m3_v_reg[1];
            p_v_reg     <= n_v_reg;
            for (int k = 0; k < DIV_N; k++)
                dv_v_reg[k] <= (k == 0) ? p_v_reg : dv_v_reg[(k == 0) ? 0 : k-1];
            f_v_reg     <= dv_v_reg[DIV_N-1];
        end
    end

    // ------------------------------------------------- output and skid regs
    logic o_v_reg, o_v_next, sk_v_next, take;
    out_t o_data_reg, o_data_next, sk_data_reg, sk_data_next;

    assign take = f_v_reg && en;

    always_comb
    begin
        o_v_next     = o_v_reg;
        o_data_next  = o_data_reg;
        sk_v_next    = sk_v_reg;
        sk_data_next = sk_data_reg;
        if (!o_v_reg || !rsp_stall)
        begin
            if (sk_v_reg)
            begin
                // Drain the skid first; the pipeline is held this cycle.
                o_v_next    = 1'b1;
                o_data_next = sk_data_reg;
                sk_v_next   = 1'b0;
            end
            else
            begin
                o_v_next = take;
                if (take)
                    o_data_next = f_out_reg;
            end
        end
        else if (take)
        begin
            // Receiver stalled: park the arriving result.
            sk_v_next    = 1'b1;
            sk_data_next = f_out_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_v_reg  <= 1'b0;
            sk_v_reg <= 1'b0;
        end
        else
        begin
            o_v_reg  <= o_v_next;
            sk_v_reg <= sk_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        o_data_reg  <= o_data_next;
        sk_data_reg <= sk_data_next;
    end

    assign rsp_valid = o_v_reg;
    assign rsp_data  = o_data_reg;

endmodule

`default_nettype wire

>>> rtl/lci_mul.sv
// Two-stage pipelined signed multiplier built from 32-bit partial products.
`default_nettype none

module lci_mul #(
    parameter int AW = 33,
    parameter int BW = 33
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic signed [AW-1:0]   a,
    input  logic signed [BW-1:0]   b,
    output logic signed [AW+BW-1:0] p
);
    localparam int LW  = 32;
    localparam int AHW = AW - LW;
    localparam int BHW = BW - LW;
    localparam int PW  = AW + BW;

    logic        [LW-1:0]      a_lo;
    logic        [LW-1:0]      b_lo;
    logic signed [AHW-1:0]     a_hi;
    logic signed [BHW-1:0]     b_hi;

    logic        [2*LW-1:0]    ll_reg;
    logic signed [AHW+LW:0]    hl_reg;
    logic signed [BHW+LW:0]    lh_reg;
    logic signed [AHW+BHW-1:0] hh_reg;
    logic        [PW-1:0]      p_reg;

    assign a_lo = a[LW-1:0];
    assign b_lo = b[LW-1:0];
    assign a_hi = a[AW-1:LW];
    assign b_hi = b[BW-1:LW];

    // Stage one: partial products.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= a_lo * b_lo;
            hl_reg <= a_hi * $signed({1'b0, b_lo});
            lh_reg <= b_hi * $signed({1'b0, a_lo});
            hh_reg <= a_hi * b_hi;
        end
    end

    // Stage two: align and sum.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= (PW'(hh_reg) << (2 * LW)) + (PW'(hl_reg) << LW)
                   + (PW'(lh_reg) << LW) + PW'(ll_reg);
        end
    end

    assign p = $signed(p_reg);

endmodule

`default_nettype wire

>>> rtl/lci_checker.sv
// Port-level checker for the line/circle intersection block, with its bind.
`default_nettype none
`include "assert_macros.svh"

module lci_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_stall,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input lci_pkg::out_t rsp_data
);
    import lci_pkg::*;

    // Stalled result holds.
    `LCI_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result changed")

    // No crossing or vertical line: all coordinates zero, no saturation.
    `LCI_ASSERT_NOW(a_empty_zero, clk, rst_n, rsp_valid && (rsp_data.status == ST_NONE || rsp_data.status == ST_VERTICAL), rsp_data.first_x == 32'sd0 && rsp_data.first_y == 32'sd0 && rsp_data.second_x == 32'sd0 && rsp_data.second_y == 32'sd0 && !rsp_data.saturated, "empty result not zero")

    // Tangent: both points coincide.
    `LCI_ASSERT_NOW(a_tangent_same, clk, rst_n, rsp_valid && rsp_data.status == ST_TANGENT, rsp_data.first_x == rsp_data.second_x && rsp_data.first_y == rsp_data.second_y, "tangent points differ")

    // Back-pressure upstream only follows a stalled result.
    `LCI_ASSERT_NOW(a_stall_cause, clk, rst_n, $rose(req_stall), $past(rsp_valid && rsp_stall), "request stall without result stall")

endmodule

bind line_circle_intersection lci_checker u_lci_checker (.*);

`default_nettype wire
